/* design/fhw_pkg.sv */
// Shared types and constants for the filter health watchdog.
// No dependencies; every other design file refers to this package by scoped names.
package fhw_pkg;

  // Width of the internal health counter
  localparam int HEALTH_WIDTH = 40;
  // Width of the reported health value
  localparam int OUT_HEALTH_W = 40;
  // Working width for health arithmetic, wide enough for a 48-bit time step
  localparam int CALC_W = ((HEALTH_WIDTH > 48) ? HEALTH_WIDTH : 48) + 2;

  localparam int TIME_W = 48;
  localparam int VEC_W = 32;
  localparam int LIMIT_W = 31;
  localparam int SQ_W = 2 * VEC_W;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Item kinds
  localparam logic [2:0] KIND_TICK = 3'd0;
  localparam logic [2:0] KIND_VISION = 3'd1;
  localparam logic [2:0] KIND_MOCAP = 3'd2;
  localparam logic [2:0] KIND_ZERO_VEL = 3'd3;
  localparam logic [2:0] KIND_CHECK = 3'd4;

  // Checked quantities
  localparam logic [1:0] QTY_ACCEL_BIAS = 2'd0;
  localparam logic [1:0] QTY_GYRO_BIAS = 2'd1;
  localparam logic [1:0] QTY_POSITION = 2'd2;
  localparam logic [1:0] QTY_VELOCITY = 2'd3;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_HEALTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VISION_INC = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MOCAP_INC = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_VEL_INC = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_LIMIT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_LIMIT = 3'd5;

  // Register reset values
  localparam logic [31:0] MAX_HEALTH_RESET = 32'd1000000;
  localparam logic [31:0] INCREMENT_RESET = 32'd100000;
  localparam logic [LIMIT_W-1:0] POSITION_LIMIT_RESET = 31'd6553600;
  localparam logic [LIMIT_W-1:0] VELOCITY_LIMIT_RESET = 31'd655360;

  // Fixed limits, unsigned Q15.16 (2.5 and 1.0)
  localparam logic [LIMIT_W-1:0] ACCEL_LIMIT = 31'd163840;
  localparam logic [LIMIT_W-1:0] GYRO_LIMIT = 31'd65536;

  // Health forced by an invalid vision source, microseconds
  localparam int INVALID_HEALTH = -100000;

  typedef struct packed {
    logic [2:0] kind;
    logic [TIME_W-1:0] time_us;
    logic vision_invalid;
    logic [1:0] quantity;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } item_t;

  typedef struct packed {
    logic signed [OUT_HEALTH_W-1:0] health_now;
    logic failed;
  } result_t;

  // Per-item status carried beside the lane products
  typedef struct packed {
    logic signed [OUT_HEALTH_W-1:0] health_now;
    logic health_fail;
    logic is_check;
  } meta_t;

endpackage

/* design/fhw_health.sv */
// Health counter, tick bookkeeping and configuration registers.
// Depends on fhw_pkg.
module fhw_health (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  fhw_pkg::item_t item,
  input  logic cfg_write,
  input  logic [fhw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fhw_pkg::CFG_DATA_W-1:0] cfg_data,
  output fhw_pkg::meta_t meta,
  output logic [fhw_pkg::VEC_W-1:0] limit
);

  localparam int HW = fhw_pkg::HEALTH_WIDTH;
  localparam int CW = fhw_pkg::CALC_W;
  localparam int OW = fhw_pkg::OUT_HEALTH_W;

  localparam logic signed [CW-1:0] HMIN_EXT = {{(CW-HW+1){1'b1}}, {(HW-1){1'b0}}};
  localparam logic signed [CW-1:0] OMIN_EXT = {{(CW-OW+1){1'b1}}, {(OW-1){1'b0}}};
  localparam logic signed [CW-1:0] OMAX_EXT = {{(CW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [CW-1:0] INVALID_EXT = CW'(fhw_pkg::INVALID_HEALTH);

  logic signed [HW-1:0] health;
  logic [fhw_pkg::TIME_W-1:0] last_tick;
  logic have_tick;

  logic [31:0] max_health;
  logic [31:0] vision_inc;
  logic [31:0] mocap_inc;
  logic [31:0] zero_vel_inc;
  logic [fhw_pkg::LIMIT_W-1:0] position_limit;
  logic [fhw_pkg::LIMIT_W-1:0] velocity_limit;

  logic signed [CW-1:0] health_ext;
  logic [fhw_pkg::TIME_W-1:0] delta;
  logic signed [CW-1:0] tick_diff;
  logic [31:0] inc;
  logic signed [CW-1:0] top_ext;
  logic signed [CW-1:0] inc_ext;
  logic signed [CW-1:0] health_next_ext;
  logic signed [CW-1:0] clip_ext;
  logic signed [HW-1:0] health_next;
  logic [fhw_pkg::TIME_W-1:0] last_tick_next;
  logic have_tick_next;
  logic [fhw_pkg::LIMIT_W-1:0] limit_sel;

  assign health_ext = CW'(health);
  assign delta = item.time_us - last_tick;
  assign tick_diff = health_ext - $signed({{(CW-fhw_pkg::TIME_W){1'b0}}, delta});
  assign top_ext = $signed({{(CW-32){1'b0}}, max_health});
  assign inc_ext = $signed({{(CW-32){1'b0}}, inc});

  // Pick the increment for this update kind
  always_comb begin
    case (item.kind)
      fhw_pkg::KIND_VISION:   inc = vision_inc;
      fhw_pkg::KIND_MOCAP:    inc = mocap_inc;
      default:                inc = zero_vel_inc;
    endcase
  end

  // Compute the next health and tick state
  always_comb begin
    health_next_ext = health_ext;
    last_tick_next = last_tick;
    have_tick_next = have_tick;
    case (item.kind) inside
      fhw_pkg::KIND_TICK: begin
        if (!have_tick) begin
          last_tick_next = item.time_us;
          have_tick_next = 1'b1;
        end else if (item.time_us >= last_tick) begin
          health_next_ext = (tick_diff < HMIN_EXT) ? HMIN_EXT : tick_diff;
          last_tick_next = item.time_us;
        end
      end
      fhw_pkg::KIND_VISION: begin
        if (item.vision_invalid) begin
          if (health_ext > 0) health_next_ext = INVALID_EXT;
        end else if (health_ext > top_ext - inc_ext) begin
          health_next_ext = top_ext;
        end else begin
          health_next_ext = health_ext + inc_ext;
        end
      end
      fhw_pkg::KIND_MOCAP, fhw_pkg::KIND_ZERO_VEL: begin
        if (health_ext > top_ext - inc_ext) health_next_ext = top_ext;
        else health_next_ext = health_ext + inc_ext;
      end
      default: ;
    endcase
  end

  assign health_next = health_next_ext[HW-1:0];

  // Clip the reported value to the output range
  always_comb begin
    if (health_next_ext > OMAX_EXT) clip_ext = OMAX_EXT;
    else if (health_next_ext < OMIN_EXT) clip_ext = OMIN_EXT;
    else clip_ext = health_next_ext;
  end

  assign meta.health_now = clip_ext[OW-1:0];
  assign meta.health_fail = health_next[HW-1];
  assign meta.is_check = (item.kind == fhw_pkg::KIND_CHECK);

  // Select the norm limit of the checked quantity
  always_comb begin
    case (item.quantity)
      fhw_pkg::QTY_ACCEL_BIAS: limit_sel = fhw_pkg::ACCEL_LIMIT;
      fhw_pkg::QTY_GYRO_BIAS:  limit_sel = fhw_pkg::GYRO_LIMIT;
      fhw_pkg::QTY_POSITION:   limit_sel = position_limit;
      default:                 limit_sel = velocity_limit;
    endcase
  end

  assign limit = {1'b0, limit_sel};

  // Hold health state; advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      health <= '0;
      last_tick <= '0;
      have_tick <= 1'b0;
    end else if (accept) begin
      health <= health_next;
      last_tick <= last_tick_next;
      have_tick <= have_tick_next;
    end
  end

  // Configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      max_health <= fhw_pkg::MAX_HEALTH_RESET;
      vision_inc <= fhw_pkg::INCREMENT_RESET;
      mocap_inc <= fhw_pkg::INCREMENT_RESET;
      zero_vel_inc <= fhw_pkg::INCREMENT_RESET;
      position_limit <= fhw_pkg::POSITION_LIMIT_RESET;
      velocity_limit <= fhw_pkg::VELOCITY_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fhw_pkg::REG_MAX_HEALTH:     max_health <= cfg_data;
        fhw_pkg::REG_VISION_INC:     vision_inc <= cfg_data;
        fhw_pkg::REG_MOCAP_INC:      mocap_inc <= cfg_data;
        fhw_pkg::REG_ZERO_VEL_INC:   zero_vel_inc <= cfg_data;
        fhw_pkg::REG_POSITION_LIMIT: position_limit <= cfg_data[fhw_pkg::LIMIT_W-1:0];
        fhw_pkg::REG_VELOCITY_LIMIT: velocity_limit <= cfg_data[fhw_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/fhw_square_lane.sv */
// One squaring lane: magnitude of a signed 32-bit word, squared into a register.
// Depends on fhw_pkg.
module fhw_square_lane (
  input  logic clk,
  input  logic en,
  input  logic [fhw_pkg::VEC_W-1:0] value,
  output logic [fhw_pkg::SQ_W-1:0] square
);

  logic [fhw_pkg::VEC_W-1:0] mag;

  // Take the magnitude; the most negative word maps to 2^31
  assign mag = value[fhw_pkg::VEC_W-1] ? (~value + 1'b1) : value;

  // Register the product
  always_ff @(posedge clk) begin
    if (en) square <= mag * mag;
  end

endmodule

/* design/fhw_merge.sv */
// Merge stage: sums the lane squares, compares with the squared limit, forms the result.
// Depends on fhw_pkg.
module fhw_merge (
  input  logic clk,
  input  logic load_stage1,
  input  logic load_stage2,
  input  fhw_pkg::meta_t meta_in,
  input  logic [fhw_pkg::SQ_W-1:0] sq_x,
  input  logic [fhw_pkg::SQ_W-1:0] sq_y,
  input  logic [fhw_pkg::SQ_W-1:0] sq_z,
  input  logic [fhw_pkg::SQ_W-1:0] sq_limit,
  output fhw_pkg::result_t result
);

  localparam int SUM_W = fhw_pkg::SQ_W + 2;

  fhw_pkg::meta_t meta;
  logic [SUM_W-1:0] norm_sq;
  logic over_limit;

  // Hold status beside the lane products
  always_ff @(posedge clk) begin
    if (load_stage1) meta <= meta_in;
  end

  assign norm_sq = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign over_limit = meta.is_check && (norm_sq > SUM_W'(sq_limit));

  // Register the result transaction
  always_ff @(posedge clk) begin
    if (load_stage2) begin
      result.health_now <= meta.health_now;
      result.failed <= meta.health_fail | over_limit;
    end
  end

endmodule

/* design/filter_health_watchdog.sv */
// Top level of the filter health watchdog: health counter, four squaring lanes, merge.
// Depends on fhw_pkg, fhw_health, fhw_square_lane and fhw_merge.
//
// Takes one transaction per clock while the result side does not stall, and returns one
// result per transaction via lane and result registers. The health counter updates in
// the cycle an item is accepted, so back-to-back updates see each other at once. Check
// items square the three vector components and the selected limit in four parallel
// 32x32 lanes; the following stage sums the squares and compares. Stall on the item side
// rises only when both pipeline stages hold a result and the result side stalls.
// Configuration writes are always ready and take effect on the next cycle.
module filter_health_watchdog (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  fhw_pkg::item_t item,
  output logic result_valid,
  input  logic result_stall,
  output fhw_pkg::result_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [fhw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fhw_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic stage1_valid;
  logic advance1;
  logic advance2;
  logic accept;
  fhw_pkg::meta_t meta;
  logic [fhw_pkg::VEC_W-1:0] limit;
  logic [fhw_pkg::SQ_W-1:0] sq_x;
  logic [fhw_pkg::SQ_W-1:0] sq_y;
  logic [fhw_pkg::SQ_W-1:0] sq_z;
  logic [fhw_pkg::SQ_W-1:0] sq_limit;

  // Advance each stage when it is empty or the stage after it moves
  assign advance2 = !result_valid || !result_stall;
  assign advance1 = !stage1_valid || advance2;
  assign item_stall = !advance1;
  assign accept = item_valid && advance1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (advance1) stage1_valid <= accept;
      if (advance2) result_valid <= stage1_valid;
    end
  end

  fhw_health u_health (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .item(item),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .meta(meta),
    .limit(limit)
  );

  fhw_square_lane u_lane_x (.clk(clk), .en(advance1), .value(item.vec_x), .square(sq_x));
  fhw_square_lane u_lane_y (.clk(clk), .en(advance1), .value(item.vec_y), .square(sq_y));
  fhw_square_lane u_lane_z (.clk(clk), .en(advance1), .value(item.vec_z), .square(sq_z));
  fhw_square_lane u_lane_limit (.clk(clk), .en(advance1), .value(limit), .square(sq_limit));

  fhw_merge u_merge (
    .clk(clk),
    .load_stage1(advance1),
    .load_stage2(advance2),
    .meta_in(meta),
    .sq_x(sq_x),
    .sq_y(sq_y),
    .sq_z(sq_z),
    .sq_limit(sq_limit),
    .result(result)
  );

endmodule

/* design/fhw_checker.sv */
// Port-level checks for the filter health watchdog, bound to the top level.
// Depends on fhw_pkg and filter_health_watchdog.
module fhw_checker (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  input  logic item_stall,
  input  logic result_valid,
  input  logic result_stall,
  input  fhw_pkg::result_t result
);

  logic [1:0] in_flight;
  logic item_take;
  logic result_take;

  assign item_take = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;

  // Count transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) in_flight <= '0;
    else in_flight <= in_flight + 2'(item_take) - 2'(result_take);
  end

  // A stalled result stays valid and unchanged
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // The input stalls only when both stages are full and the output is held
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (in_flight == 2'd2) && result_stall)
    else $error("input stalled with room in the pipeline");

  // Never more than two transactions in flight
  assert property (@(posedge clk) disable iff (rst) in_flight != 2'd3)
    else $error("pipeline occupancy overflow");

  // A negative health always reports failure
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.health_now[fhw_pkg::OUT_HEALTH_W-1] |-> result.failed)
    else $error("negative health without failure");

endmodule

bind filter_health_watchdog fhw_checker u_fhw_checker (
  .clk(clk),
  .rst(rst),
  .item_valid(item_valid),
  .item_stall(item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result(result)
);

/* test/tb_filter_health_watchdog.sv */
// Self-checking testbench for filter_health_watchdog.
// Depends on fhw_pkg and the design top; keeps its own health counter and norm checks,
// predicts one result per transaction and compares results in order.
module tb_filter_health_watchdog;
  import fhw_pkg::*;

  // Item kinds the block has no meaning for
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST = 3'd7;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS = 350;
  localparam longint HEALTH_TOP = (longint'(1) <<< (HEALTH_WIDTH - 1)) - 1;
  localparam longint HEALTH_BOTTOM = -HEALTH_TOP - 1;
  localparam longint REPORT_TOP = (longint'(1) <<< (OUT_HEALTH_W - 1)) - 1;
  localparam longint REPORT_BOTTOM = -REPORT_TOP - 1;

  logic clk = 1'b0;
  logic rst;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predicted state of the health counter and its registers
  longint health_us;
  logic [TIME_W-1:0] last_tick_us;
  bit tick_seen;
  logic [31:0] max_health_us;
  logic [31:0] vision_inc_us;
  logic [31:0] mocap_inc_us;
  logic [31:0] zero_vel_inc_us;
  logic [LIMIT_W-1:0] position_lim;
  logic [LIMIT_W-1:0] velocity_lim;

  result_t pending_health[$];
  int items_sent = 0;
  int results_seen = 0;
  int error_count = 0;
  bit calm = 1'b0;
  int stall_left = 0;
  logic [TIME_W-1:0] stim_time_us;

  filter_health_watchdog dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void reset_health_model();
    health_us = 0;
    last_tick_us = '0;
    tick_seen = 1'b0;
    max_health_us = MAX_HEALTH_RESET;
    vision_inc_us = INCREMENT_RESET;
    mocap_inc_us = INCREMENT_RESET;
    zero_vel_inc_us = INCREMENT_RESET;
    position_lim = POSITION_LIMIT_RESET;
    velocity_lim = VELOCITY_LIMIT_RESET;
  endfunction

  function automatic void store_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MAX_HEALTH: max_health_us = data;
      REG_VISION_INC: vision_inc_us = data;
      REG_MOCAP_INC: mocap_inc_us = data;
      REG_ZERO_VEL_INC: zero_vel_inc_us = data;
      REG_POSITION_LIMIT: position_lim = data[LIMIT_W-1:0];
      REG_VELOCITY_LIMIT: velocity_lim = data[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // Add credit, clamping at the configured ceiling
  function automatic void add_credit(input logic [31:0] inc);
    longint top;
    longint room;
    top = longint'({32'd0, max_health_us});
    room = top - longint'({32'd0, inc});
    if (health_us > room) health_us = top;
    else health_us = health_us + longint'({32'd0, inc});
  endfunction

  function automatic logic [2*VEC_W+1:0] square_mag(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W:0] w;
    logic [2*VEC_W+1:0] m;
    w = v;
    if (w < 0) w = -w;
    m = '0;
    m[VEC_W:0] = w;
    return m * m;
  endfunction

  // Work out the result of one transaction and advance the predicted state
  function automatic result_t predict_health(input item_t it);
    longint span;
    longint floor_h;
    longint shown;
    logic [LIMIT_W-1:0] lim;
    logic [2*VEC_W+1:0] lim_sq;
    logic [2*VEC_W+1:0] norm_sq;
    logic fail;
    result_t r;
    fail = 1'b0;
    case (it.kind)
      KIND_TICK: begin
        if (!tick_seen) begin
          last_tick_us = it.time_us;
          tick_seen = 1'b1;
        end else if (it.time_us >= last_tick_us) begin
          span = longint'({16'd0, it.time_us - last_tick_us});
          floor_h = HEALTH_BOTTOM + span;
          if (health_us < floor_h) health_us = HEALTH_BOTTOM;
          else health_us = health_us - span;
          last_tick_us = it.time_us;
        end
      end
      KIND_VISION: begin
        if (it.vision_invalid) begin
          if (health_us > 0) health_us = INVALID_HEALTH;
        end else begin
          add_credit(vision_inc_us);
        end
      end
      KIND_MOCAP: add_credit(mocap_inc_us);
      KIND_ZERO_VEL: add_credit(zero_vel_inc_us);
      KIND_CHECK: begin
        case (it.quantity)
          QTY_ACCEL_BIAS: lim = ACCEL_LIMIT;
          QTY_GYRO_BIAS: lim = GYRO_LIMIT;
          QTY_POSITION: lim = position_lim;
          default: lim = velocity_lim;
        endcase
        lim_sq = '0;
        lim_sq[LIMIT_W-1:0] = lim;
        lim_sq = lim_sq * lim_sq;
        norm_sq = square_mag(it.vec_x) + square_mag(it.vec_y) + square_mag(it.vec_z);
        if (norm_sq > lim_sq) fail = 1'b1;
      end
      default: ;
    endcase
    if (health_us < 0) fail = 1'b1;
    shown = health_us;
    if (shown > REPORT_TOP) shown = REPORT_TOP;
    if (shown < REPORT_BOTTOM) shown = REPORT_BOTTOM;
    r.health_now = shown[OUT_HEALTH_W-1:0];
    r.failed = fail;
    return r;
  endfunction

  // Record accepted transactions and check each accepted result
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) store_register(cfg_index, cfg_data);
      if (item_valid && !item_stall) pending_health.push_back(predict_health(item));
      if (result_valid && !result_stall) begin
        results_seen++;
        if (pending_health.size() == 0) begin
          $error("result with no transaction pending: health_now %0d failed %0b",
                 result.health_now, result.failed);
          error_count++;
        end else begin
          want = pending_health.pop_front();
          if (result.health_now !== want.health_now) begin
            $error("health_now: expected %0d actual %0d", want.health_now,
                   result.health_now);
            error_count++;
          end
          if (result.failed !== want.failed) begin
            $error("failed: expected %0b actual %0b", want.failed, result.failed);
            error_count++;
          end
        end
      end
    end
  end

  // Stall the result side: short random stalls with an occasional long one
  always @(posedge clk) begin
    if (calm) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      stall_left <= $urandom_range(8, 40);
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random content everywhere, so fields that do not apply are exercised too
  function automatic item_t junk_item();
    item_t it;
    it.kind = 3'($urandom_range(0, 7));
    it.time_us = TIME_W'({$urandom(), $urandom()});
    it.vision_invalid = 1'($urandom_range(0, 1));
    it.quantity = 2'($urandom_range(0, 3));
    it.vec_x = $urandom();
    it.vec_y = $urandom();
    it.vec_z = $urandom();
    return it;
  endfunction

  function automatic item_t tick_at(input logic [TIME_W-1:0] t);
    item_t it;
    it = junk_item();
    it.kind = KIND_TICK;
    it.time_us = t;
    return it;
  endfunction

  function automatic item_t update_of(input logic [2:0] kind, input logic invalid);
    item_t it;
    it = junk_item();
    it.kind = kind;
    it.vision_invalid = invalid;
    return it;
  endfunction

  function automatic item_t check_of(input logic [1:0] qty, input logic signed [31:0] x,
                                     input logic signed [31:0] y,
                                     input logic signed [31:0] z);
    item_t it;
    it = junk_item();
    it.kind = KIND_CHECK;
    it.quantity = qty;
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    return it;
  endfunction

  // Present one transaction and hold it until accepted
  task automatic send_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    wait (results_seen == items_sent);
  endtask

  // Write all six registers once the block has gone idle
  task automatic write_config(input logic [31:0] max_h, input logic [31:0] vis,
                              input logic [31:0] moc, input logic [31:0] zv,
                              input logic [31:0] pos, input logic [31:0] vel);
    logic [31:0] vals[6];
    logic [CFG_INDEX_W-1:0] regs[6];
    vals = '{max_h, vis, moc, zv, pos, vel};
    regs = '{REG_MAX_HEALTH, REG_VISION_INC, REG_MOCAP_INC, REG_ZERO_VEL_INC,
             REG_POSITION_LIMIT, REG_VELOCITY_LIMIT};
    drain_results();
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Tick, update and check behavior under the reset register values
  task automatic test_directed_sequence();
    logic signed [31:0] most_neg;
    most_neg = 32'sh8000_0000;
    send_item(check_of(QTY_ACCEL_BIAS, 0, 0, 0));
    send_item(tick_at(48'd1000));
    send_item(tick_at(48'd400));
    send_item(tick_at(48'd1000));
    send_item(update_of(KIND_VISION, 1'b0));
    send_item(update_of(KIND_MOCAP, 1'b0));
    send_item(update_of(KIND_ZERO_VEL, 1'b1));
    send_item(tick_at(48'd51000));
    send_item(update_of(KIND_VISION, 1'b1));
    send_item(update_of(KIND_VISION, 1'b1));
    send_item(update_of(KIND_ZERO_VEL, 1'b0));
    send_item(update_of(KIND_SPARE_FIRST, 1'b0));
    send_item(update_of(KIND_SPARE_LAST, 1'b1));
    send_item(check_of(QTY_ACCEL_BIAS, 163840, 0, 0));
    send_item(check_of(QTY_ACCEL_BIAS, 0, -163841, 0));
    send_item(check_of(QTY_GYRO_BIAS, 0, 0, 65536));
    send_item(check_of(QTY_GYRO_BIAS, 46341, -46341, 0));
    send_item(check_of(QTY_POSITION, -6553600, 0, 0));
    send_item(check_of(QTY_VELOCITY, 0, 655361, 0));
    send_item(check_of(QTY_ACCEL_BIAS, most_neg, most_neg, most_neg));
    send_item(check_of(QTY_GYRO_BIAS, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_item(check_of(QTY_POSITION, most_neg, most_neg, most_neg));
    send_item(check_of(QTY_VELOCITY, most_neg, most_neg, most_neg));
    stim_time_us = 48'd51000;
  endtask

  // Extreme register values, and health above a lowered ceiling
  task automatic test_register_extremes();
    logic signed [31:0] most_neg;
    most_neg = 32'sh8000_0000;
    write_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(update_of(KIND_MOCAP, 1'b0));
    send_item(check_of(QTY_POSITION, 1, 0, 0));
    send_item(check_of(QTY_VELOCITY, 0, 0, 0));
    write_config('1, '1, '1, '1, '1, 32'h7FFF_FFFF);
    send_item(update_of(KIND_VISION, 1'b0));
    send_item(update_of(KIND_MOCAP, 1'b0));
    send_item(check_of(QTY_POSITION, most_neg, most_neg, most_neg));
    send_item(check_of(QTY_VELOCITY, 32'sh7FFF_FFFF, 0, 0));
    write_config(32'd500, 32'd1, 32'd2, 32'd3, 32'(POSITION_LIMIT_RESET),
                 32'(VELOCITY_LIMIT_RESET));
    send_item(update_of(KIND_MOCAP, 1'b0));
    send_item(update_of(KIND_VISION, 1'b0));
    stim_time_us = stim_time_us + 48'd100;
    send_item(tick_at(stim_time_us));
  endtask

  function automatic logic signed [31:0] pick_component(input logic [LIMIT_W-1:0] lim);
    int r;
    logic signed [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom();
    if (r < 25) return 0;
    v = $urandom_range(0, lim);
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  function automatic item_t random_check();
    item_t it;
    logic [LIMIT_W-1:0] lim;
    logic signed [31:0] edge_v;
    it = check_of(2'($urandom_range(0, 3)), 0, 0, 0);
    case (it.quantity)
      QTY_ACCEL_BIAS: lim = ACCEL_LIMIT;
      QTY_GYRO_BIAS: lim = GYRO_LIMIT;
      QTY_POSITION: lim = position_lim;
      default: lim = velocity_lim;
    endcase
    if ($urandom_range(0, 99) < 8) begin
      // land exactly on the limit or one step past it
      edge_v = {1'b0, lim} + 32'($urandom_range(0, 1));
      it.vec_x = ($urandom_range(0, 1) != 0) ? -edge_v : edge_v;
    end else begin
      it.vec_x = pick_component(lim);
      it.vec_y = pick_component(lim);
      it.vec_z = pick_component(lim);
    end
    return it;
  endfunction

  function automatic item_t random_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6 && stim_time_us > 48'd1000)
      return tick_at(stim_time_us - TIME_W'($urandom_range(1, 1000)));
    if (r < 12) return tick_at(stim_time_us);
    if (r < 15) stim_time_us = stim_time_us + TIME_W'($urandom_range(0, 1 << 22));
    else stim_time_us = stim_time_us + TIME_W'($urandom_range(0, 120000));
    return tick_at(stim_time_us);
  endfunction

  // Mixed random traffic over several register settings
  task automatic test_random_traffic();
    int r;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_config($urandom_range(0, 3000000), $urandom_range(0, 150000),
                   $urandom_range(0, 150000), $urandom_range(0, 150000),
                   ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 22),
                   ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 21));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) calm = ($urandom_range(0, 99) < 20);
        r = $urandom_range(0, 99);
        if (r < 30) send_item(random_tick());
        else if (r < 42) send_item(update_of(KIND_VISION, $urandom_range(0, 99) < 15));
        else if (r < 52) send_item(update_of(KIND_MOCAP, 1'($urandom_range(0, 1))));
        else if (r < 62) send_item(update_of(KIND_ZERO_VEL, 1'b0));
        else if (r < 97) send_item(random_check());
        else send_item(update_of(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                                 1'($urandom_range(0, 1))));
      end
      calm = 1'b0;
    end
  endtask

  // Largest timestamp: health saturates low, then every later earlier tick is ignored
  task automatic test_time_extremes();
    send_item(tick_at({TIME_W{1'b1}}));
    send_item(check_of(QTY_ACCEL_BIAS, 0, 0, 0));
    send_item(update_of(KIND_VISION, 1'b1));
    send_item(update_of(KIND_ZERO_VEL, 1'b0));
    send_item(tick_at(TIME_W'({$urandom(), $urandom()})));
    send_item(tick_at({TIME_W{1'b1}}));
  endtask

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    result_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    stim_time_us = '0;
    reset_health_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_sequence();
    test_register_extremes();
    test_random_traffic();
    test_time_extremes();
    drain_results();
    repeat (5) @(posedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
